/* rtl/swfc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the sliding weighted frame checksum.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package swfc_pkg;

  localparam int WINDOW_COUNT_BITS = 28;
  localparam int OFFSET_INDEX_BITS = 13;

  localparam int FRAME_BITS      = 32;
  localparam int CHECKSUM_BITS   = 32;
  localparam int READ_OFS_BITS   = 14;
  localparam int WIN_LEN_BITS    = 28;
  localparam int FIRST_OFS_BITS  = 12;
  localparam int MULT_BITS       = 32;

  localparam int APB_ADDR_BITS   = 3;
  localparam int APB_DATA_BITS   = 32;

  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    REG_WINDOW_LENGTH,
    REG_FIRST_OFFSET
  } reg_idx_e;

  typedef enum logic {
    OP_FILL,
    OP_SLIDE
  } op_e;

  typedef struct packed {
    logic [WIN_LEN_BITS-1:0]   window_length;
    logic [FIRST_OFS_BITS-1:0] first_offset;
  } cfg_t;

  // One unit of work for the arithmetic side.
  typedef struct packed {
    op_e                           op;
    logic                          clear;
    logic [FRAME_BITS-1:0]         incoming;
    logic [FRAME_BITS-1:0]         outgoing;
    logic [MULT_BITS-1:0]          weight;
    logic                          emit;
    logic signed [READ_OFS_BITS-1:0] read_offset;
    logic                          last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* rtl/swfc_in_if.sv */
`timescale 1ns / 1ps
// Input channel: valid/ready handshake carrying one frame request.
// Uses swfc_pkg for field widths.
interface swfc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [swfc_pkg::FRAME_BITS-1:0]      incoming_frame;
  logic [swfc_pkg::FRAME_BITS-1:0]      outgoing_frame;
  logic                                 sweep_start;
  logic                                 sweep_end;

  modport source (output valid, incoming_frame, outgoing_frame, sweep_start, sweep_end,
                  input ready);
  modport sink (input valid, incoming_frame, outgoing_frame, sweep_start, sweep_end,
                output ready);
endinterface

/* rtl/swfc_out_if.sv */
`timescale 1ns / 1ps
// Result channel: valid/ready handshake carrying one checksum request.
// Uses swfc_pkg for field widths.
interface swfc_out_if;
  logic                                        valid;
  logic                                        ready;
  logic [swfc_pkg::CHECKSUM_BITS-1:0]          checksum;
  logic signed [swfc_pkg::READ_OFS_BITS-1:0]   read_offset;
  logic                                        last;

  modport source (output valid, checksum, read_offset, last, input ready);
  modport sink (input valid, checksum, read_offset, last, output ready);
endinterface

/* rtl/sliding_weighted_frame_checksum.sv */
`timescale 1ns / 1ps
// Top level of the sliding weighted frame checksum: register file, front end,
// command queue and arithmetic back end. Depends on swfc_pkg and both channel interfaces.
//
//   port       dir   kind            carries
//   in_i       in    valid/ready     incoming_frame, outgoing_frame, sweep_start, sweep_end
//   out_o      out   valid/ready     checksum, read_offset, last
//   psel..     in    APB             window_length (0x0), first_offset (0x4)
//
// One frame request per cycle is sustained while the queue has room; the weighted-sum
// update in the back end is the loop that sets this rate.
// A taken request passes the queue, the multiply register and the checksum register.
// Reset clears all counters and sums at once; no clearing pass is needed.
// The four-entry queue lets the input keep flowing while the result side stalls.
module sliding_weighted_frame_checksum #(
  parameter int WindowCountBits = swfc_pkg::WINDOW_COUNT_BITS,
  parameter int OffsetIndexBits = swfc_pkg::OFFSET_INDEX_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  swfc_in_if.sink                              in_i,
  swfc_out_if.source                           out_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [swfc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [swfc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [swfc_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready
);

  swfc_pkg::cfg_t       cfg;
  swfc_pkg::cmd_t       push_cmd, head_cmd;
  swfc_pkg::q_status_t  q_status;
  logic                 q_push, q_pop;

  swfc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  swfc_front #(
    .WindowCountBits (WindowCountBits),
    .OffsetIndexBits (OffsetIndexBits)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg),
    .q_status_i (q_status),
    .push_o     (q_push),
    .cmd_o      (push_cmd)
  );

  swfc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (push_cmd),
    .pop_i      (q_pop),
    .head_o     (head_cmd),
    .status_o   (q_status)
  );

  swfc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head_cmd),
    .q_status_i (q_status),
    .pop_o      (q_pop),
    .out_o      (out_o)
  );

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_status.full)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_status.empty)
    else $error("command popped from an empty queue");

  a_empty_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_status.empty && !q_push) |=> q_status.empty)
    else $error("queue filled without a push");
`endif

endmodule

/* rtl/swfc_cfg.sv */
`timescale 1ns / 1ps
// APB-style register file: window length and first read offset.
// Depends on swfc_pkg.
module swfc_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [swfc_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [swfc_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [swfc_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                 pready,
  output swfc_pkg::cfg_t                       cfg_o
);

  logic [swfc_pkg::WIN_LEN_BITS-1:0]   window_length_q, window_length_d;
  logic [swfc_pkg::FIRST_OFS_BITS-1:0] first_offset_q, first_offset_d;
  swfc_pkg::reg_idx_e                  reg_idx;
  logic                                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = swfc_pkg::reg_idx_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;

  always_comb begin
    window_length_d = window_length_q;
    first_offset_d  = first_offset_q;
    prdata          = '0;
    unique case (reg_idx)
      swfc_pkg::REG_WINDOW_LENGTH: begin
        prdata = swfc_pkg::APB_DATA_BITS'(window_length_q);
        if (wr_en) begin
          window_length_d = pwdata[swfc_pkg::WIN_LEN_BITS-1:0];
        end
      end
      swfc_pkg::REG_FIRST_OFFSET: begin
        prdata = swfc_pkg::APB_DATA_BITS'(first_offset_q);
        if (wr_en) begin
          first_offset_d = pwdata[swfc_pkg::FIRST_OFS_BITS-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= swfc_pkg::WIN_LEN_BITS'(1);
      first_offset_q  <= '0;
    end else begin
      window_length_q <= window_length_d;
      first_offset_q  <= first_offset_d;
    end
  end

  assign cfg_o.window_length = window_length_q;
  assign cfg_o.first_offset  = first_offset_q;

endmodule

/* rtl/swfc_front.sv */
`timescale 1ns / 1ps
// Front end: accepts frame requests, tracks sweep, fill and offset counters,
// and turns each request into a fill or slide command. Depends on swfc_pkg.
module swfc_front #(
  parameter int WindowCountBits = swfc_pkg::WINDOW_COUNT_BITS,
  parameter int OffsetIndexBits = swfc_pkg::OFFSET_INDEX_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  swfc_in_if.sink               in_i,
  input  swfc_pkg::cfg_t        cfg_i,
  input  swfc_pkg::q_status_t   q_status_i,
  output logic                  push_o,
  output swfc_pkg::cmd_t        cmd_o
);

  logic [WindowCountBits-1:0] len_m, len_eff;
  logic [WindowCountBits-1:0] fill_q, fill_d, fill_cur, fill_inc, fill_next;
  logic [OffsetIndexBits-1:0] oi_q, oi_d, oi_cur, oi_next;
  logic                       active_q, active_d, active_cur;
  logic                       accept, is_fill, emit;
  logic signed [swfc_pkg::READ_OFS_BITS-1:0] base_ofs;

  assign in_i.ready = ~q_status_i.full;
  assign accept     = in_i.valid & ~q_status_i.full;

  always_comb begin
    len_m      = WindowCountBits'(cfg_i.window_length);
    len_eff    = (len_m == '0) ? WindowCountBits'(1) : len_m;
    active_cur = in_i.sweep_start | active_q;
    fill_cur   = in_i.sweep_start ? '0 : fill_q;
    oi_cur     = in_i.sweep_start ? '0 : oi_q;
    fill_inc   = fill_cur + WindowCountBits'(1);
    is_fill    = fill_cur < len_eff;
    base_ofs   = {{(swfc_pkg::READ_OFS_BITS - swfc_pkg::FIRST_OFS_BITS)
                   {cfg_i.first_offset[swfc_pkg::FIRST_OFS_BITS-1]}},
                  cfg_i.first_offset};

    cmd_o          = '0;
    cmd_o.clear    = in_i.sweep_start;
    cmd_o.incoming = in_i.incoming_frame;
    cmd_o.outgoing = in_i.outgoing_frame;
    if (is_fill) begin
      fill_next    = fill_inc;
      oi_next      = oi_cur;
      emit         = (fill_inc == len_eff);
      cmd_o.op     = swfc_pkg::OP_FILL;
      cmd_o.weight = swfc_pkg::MULT_BITS'(fill_inc);
    end else begin
      fill_next    = fill_cur;
      oi_next      = oi_cur + OffsetIndexBits'(1);
      emit         = 1'b1;
      cmd_o.op     = swfc_pkg::OP_SLIDE;
      cmd_o.weight = swfc_pkg::MULT_BITS'(len_eff);
    end
    cmd_o.emit        = emit;
    cmd_o.last        = emit & in_i.sweep_end;
    cmd_o.read_offset = base_ofs + swfc_pkg::READ_OFS_BITS'(oi_next);

    // Drop requests that arrive outside a sweep.
    push_o   = accept & active_cur;
    fill_d   = fill_q;
    oi_d     = oi_q;
    active_d = active_q;
    if (push_o) begin
      fill_d   = fill_next;
      oi_d     = oi_next;
      active_d = ~(emit & in_i.sweep_end);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      oi_q     <= '0;
      active_q <= 1'b0;
    end else begin
      fill_q   <= fill_d;
      oi_q     <= oi_d;
      active_q <= active_d;
    end
  end

endmodule

/* rtl/swfc_queue.sv */
`timescale 1ns / 1ps
// Short command queue between the front end and the arithmetic back end.
// Depends on swfc_pkg.
module swfc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  swfc_pkg::cmd_t        push_cmd_i,
  input  logic                  pop_i,
  output swfc_pkg::cmd_t        head_o,
  output swfc_pkg::q_status_t   status_o
);

  swfc_pkg::cmd_t                   mem_q [swfc_pkg::QUEUE_DEPTH];
  logic [swfc_pkg::QPTR_BITS-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [swfc_pkg::QCNT_BITS-1:0]   count_q, count_d;

  localparam logic [swfc_pkg::QPTR_BITS-1:0] LastPtr =
    swfc_pkg::QPTR_BITS'(swfc_pkg::QUEUE_DEPTH - 1);

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == swfc_pkg::QCNT_BITS'(swfc_pkg::QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + swfc_pkg::QPTR_BITS'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + swfc_pkg::QPTR_BITS'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + swfc_pkg::QCNT_BITS'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - swfc_pkg::QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* rtl/swfc_back.sv */
`timescale 1ns / 1ps
// Back end: multiplies the entering frame by its weight, then updates the
// running and weighted sums and registers the checksum request. Depends on swfc_pkg.
module swfc_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swfc_pkg::cmd_t        head_i,
  input  swfc_pkg::q_status_t   q_status_i,
  output logic                  pop_o,
  swfc_out_if.source            out_o
);

  logic                                s1_valid_q, s1_valid_d;
  swfc_pkg::cmd_t                      s1_cmd_q;
  logic [swfc_pkg::FRAME_BITS-1:0]     s1_prod_q;
  logic [swfc_pkg::CHECKSUM_BITS-1:0]  run_q, run_d, wsum_q, wsum_d;
  logic                                out_valid_q, out_valid_d;
  logic [swfc_pkg::CHECKSUM_BITS-1:0]  checksum_q;
  logic signed [swfc_pkg::READ_OFS_BITS-1:0] read_offset_q;
  logic                                last_q;
  logic                                out_free, s1_adv;

  assign out_free = ~out_valid_q | out_o.ready;
  assign s1_adv   = s1_valid_q & (~s1_cmd_q.emit | out_free);
  assign pop_o    = ~q_status_i.empty & (~s1_valid_q | s1_adv);

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (pop_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end

    run_d  = run_q;
    wsum_d = wsum_q;
    unique case (s1_cmd_q.op)
      swfc_pkg::OP_FILL: begin
        if (s1_cmd_q.clear) begin
          run_d  = s1_cmd_q.incoming;
          wsum_d = s1_prod_q;
        end else begin
          run_d  = run_q + s1_cmd_q.incoming;
          wsum_d = wsum_q + s1_prod_q;
        end
      end
      swfc_pkg::OP_SLIDE: begin
        wsum_d = wsum_q - run_q + s1_prod_q;
        run_d  = run_q - s1_cmd_q.outgoing + s1_cmd_q.incoming;
      end
      default: begin
        run_d  = run_q;
        wsum_d = wsum_q;
      end
    endcase

    out_valid_d = out_valid_q;
    if (s1_adv && s1_cmd_q.emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      run_q       <= '0;
      wsum_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        run_q  <= run_d;
        wsum_q <= wsum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_cmd_q  <= head_i;
      s1_prod_q <= head_i.incoming * head_i.weight;
    end
    if (s1_adv && s1_cmd_q.emit) begin
      checksum_q    <= wsum_d;
      read_offset_q <= s1_cmd_q.read_offset;
      last_q        <= s1_cmd_q.last;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.checksum    = checksum_q;
  assign out_o.read_offset = read_offset_q;
  assign out_o.last        = last_q;

endmodule

/* tb/sliding_weighted_frame_checksum_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for sliding_weighted_frame_checksum: queue-fed driver,
// result monitor and rolling checksum predictor. Needs swfc_pkg and both channel interfaces.
module sliding_weighted_frame_checksum_tb;
  import swfc_pkg::*;

  localparam int LONG_HOLD    = 100;
  localparam int DRAIN_CYCLES = 12;
  localparam int SETTLE_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int LONG_SLIDES  = 250;

  typedef struct {
    bit [FRAME_BITS-1:0] incoming_frame;
    bit [FRAME_BITS-1:0] outgoing_frame;
    bit                  sweep_start;
    bit                  sweep_end;
  } frame_req_t;

  typedef struct {
    bit [CHECKSUM_BITS-1:0] checksum;
    bit [READ_OFS_BITS-1:0] read_offset;
    bit                     last;
  } checksum_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic pready;

  swfc_in_if  frame_ch ();
  swfc_out_if sum_ch ();

  sliding_weighted_frame_checksum dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (frame_ch),
    .out_o   (sum_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Register copies and rolling checksum state
  bit [WIN_LEN_BITS-1:0]      cfg_win_len = WIN_LEN_BITS'(1);
  bit [FIRST_OFS_BITS-1:0]    cfg_first_ofs = '0;
  bit [CHECKSUM_BITS-1:0]     sum_run;
  bit [CHECKSUM_BITS-1:0]     sum_weighted;
  bit [WINDOW_COUNT_BITS-1:0] fill_cnt;
  bit [OFFSET_INDEX_BITS-1:0] ofs_idx;
  bit                         sweep_on;

  frame_req_t    frame_q[$];
  checksum_res_t checksum_q[$];
  int  frames_pushed;
  int  frames_taken;
  int  fail_count;
  bit  in_taken;
  bit  res_taken;
  bit  src_busy;
  bit  snk_busy;
  int  src_wait;
  int  snk_wait;
  int  hold_serial;
  int  hold_seen;

  function automatic int draw_gap(bit busy);
    return busy ? $urandom_range(0, 6) : 0;
  endfunction

  function automatic bit next_checksum(input frame_req_t req, output checksum_res_t res);
    bit [WINDOW_COUNT_BITS-1:0] len;
    len = (cfg_win_len == '0) ? WINDOW_COUNT_BITS'(1) : WINDOW_COUNT_BITS'(cfg_win_len);
    res = '{default: '0};
    if (req.sweep_start) begin
      sum_run      = '0;
      sum_weighted = '0;
      fill_cnt     = '0;
      ofs_idx      = '0;
      sweep_on     = 1'b1;
    end
    if (!sweep_on) return 1'b0;
    if (fill_cnt < len) begin
      fill_cnt     = fill_cnt + 1'b1;
      sum_run      = sum_run + req.incoming_frame;
      sum_weighted = sum_weighted + req.incoming_frame * CHECKSUM_BITS'(fill_cnt);
      if (fill_cnt != len) return 1'b0;
    end else begin
      sum_weighted = sum_weighted - sum_run + req.incoming_frame * CHECKSUM_BITS'(len);
      sum_run      = sum_run - req.outgoing_frame + req.incoming_frame;
      ofs_idx      = ofs_idx + 1'b1;
    end
    res.checksum    = sum_weighted;
    res.read_offset = READ_OFS_BITS'({{(READ_OFS_BITS - FIRST_OFS_BITS){cfg_first_ofs[FIRST_OFS_BITS-1]}},
                                      cfg_first_ofs} + READ_OFS_BITS'(ofs_idx));
    res.last        = req.sweep_end;
    if (req.sweep_end) sweep_on = 1'b0;
    return 1'b1;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Frame driver: hold a request until taken, then idle for a drawn gap
  always @(negedge clk_i) begin
    frame_req_t req;
    if (!rst_ni) begin
      frame_ch.valid <= 1'b0;
      src_wait = 0;
    end else if (!(frame_ch.valid && !in_taken)) begin
      if (in_taken) src_wait = draw_gap(src_busy);
      if (src_wait > 0) begin
        src_wait--;
        frame_ch.valid <= 1'b0;
      end else if (frame_q.size() > 0) begin
        req = frame_q.pop_front();
        frame_ch.valid          <= 1'b1;
        frame_ch.incoming_frame <= req.incoming_frame;
        frame_ch.outgoing_frame <= req.outgoing_frame;
        frame_ch.sweep_start    <= req.sweep_start;
        frame_ch.sweep_end      <= req.sweep_end;
      end else begin
        frame_ch.valid <= 1'b0;
      end
    end
  end

  // Result acceptor: random stall after each result, long hold-off on request
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      sum_ch.ready <= 1'b0;
      snk_wait = 0;
    end else begin
      if (hold_seen != hold_serial) begin
        hold_seen = hold_serial;
        snk_wait  = LONG_HOLD;
      end else if (res_taken) begin
        snk_wait = draw_gap(snk_busy);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        sum_ch.ready <= 1'b0;
      end else begin
        sum_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: check results against the oldest expectation, predict on accepted frames
  always @(posedge clk_i) begin
    frame_req_t    req;
    checksum_res_t res;
    checksum_res_t want;
    if (rst_ni) begin
      in_taken  <= frame_ch.valid && frame_ch.ready;
      res_taken <= sum_ch.valid && sum_ch.ready;
      if (sum_ch.valid && sum_ch.ready) begin
        if (checksum_q.size() == 0) begin
          note_failure($sformatf("unexpected result: checksum %h read_offset %0d last %0b",
                                 sum_ch.checksum, sum_ch.read_offset, sum_ch.last));
        end else begin
          want = checksum_q.pop_front();
          if (sum_ch.checksum !== want.checksum || sum_ch.read_offset !== want.read_offset ||
              sum_ch.last !== want.last) begin
            note_failure($sformatf({"mismatch: checksum exp %h got %h, read_offset exp %0d ",
                                    "got %0d, last exp %0b got %0b"},
                                   want.checksum, sum_ch.checksum,
                                   $signed(want.read_offset), sum_ch.read_offset,
                                   want.last, sum_ch.last));
          end
        end
      end
      if (frame_ch.valid && frame_ch.ready) begin
        frames_taken++;
        req.incoming_frame = frame_ch.incoming_frame;
        req.outgoing_frame = frame_ch.outgoing_frame;
        req.sweep_start    = frame_ch.sweep_start;
        req.sweep_end      = frame_ch.sweep_end;
        if (next_checksum(req, res)) checksum_q.insert(checksum_q.size(), res);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic write_reg(reg_idx_e idx, logic [APB_DATA_BITS-1:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = APB_ADDR_BITS'(int'(idx) << 2);
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    if (idx == REG_WINDOW_LENGTH) cfg_win_len = value[WIN_LEN_BITS-1:0];
    else cfg_first_ofs = value[FIRST_OFS_BITS-1:0];
  endtask

  task automatic push_frame(bit [FRAME_BITS-1:0] inc, bit [FRAME_BITS-1:0] outg,
                            bit start, bit stop);
    frame_q.insert(frame_q.size(), '{inc, outg, start, stop});
    frames_pushed++;
  endtask

  function automatic bit [FRAME_BITS-1:0] rand_frame();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Fill then slide; an untidy sweep may restart or end during fill, or never end
  task automatic queue_sweep(int len, int slides, bit tidy);
    int k;
    for (k = 0; k < len; k++) begin
      push_frame(rand_frame(), rand_frame(),
                 k == 0 || (!tidy && $urandom_range(0, 39) == 0),
                 !tidy && $urandom_range(0, 9) == 0);
    end
    for (k = 0; k < slides; k++) begin
      push_frame(rand_frame(), rand_frame(), 1'b0,
                 k == slides - 1 && (tidy || $urandom_range(0, 7) != 0));
    end
  endtask

  // Wait for every frame to be taken and every checksum to arrive, then let the pipe empty
  task automatic settle();
    int c;
    wait (frames_taken == frames_pushed);
    for (c = 0; c < SETTLE_LIMIT && checksum_q.size() != 0; c++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int base;
    int len_raw;
    int len;
    int sweeps;
    bit [FIRST_OFS_BITS-1:0] ofs;

    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    frame_ch.valid          = 1'b0;
    frame_ch.incoming_frame = '0;
    frame_ch.outgoing_frame = '0;
    frame_ch.sweep_start    = 1'b0;
    frame_ch.sweep_end      = 1'b0;
    sum_ch.ready            = 1'b0;
    src_busy = 1'b1;
    snk_busy = 1'b1;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: window of one frame, offset zero
    push_frame(32'hDEAD_BEEF, 32'h0, 1'b0, 1'b1);
    push_frame('1, 32'h1234_5678, 1'b1, 1'b0);
    push_frame('0, '1, 1'b0, 1'b0);
    push_frame('1, '0, 1'b0, 1'b1);
    push_frame(32'h5555_AAAA, 32'hAAAA_5555, 1'b0, 1'b1);
    settle();

    // Masked length, lowest offset, end during fill, restart mid-sweep
    write_reg(REG_WINDOW_LENGTH, 32'hF000_0004);
    write_reg(REG_FIRST_OFFSET, 32'hFFFF_F800);
    push_frame('1, '1, 1'b1, 1'b0);
    push_frame(32'h8000_0001, 32'h0, 1'b0, 1'b0);
    push_frame(32'h7FFF_FFFE, '1, 1'b0, 1'b1);
    push_frame(32'h0000_FFFF, 32'h0, 1'b1, 1'b0);
    push_frame(32'hFFFF_0000, 32'h0, 1'b0, 1'b0);
    push_frame('1, 32'h0, 1'b0, 1'b0);
    push_frame(32'h0000_0001, 32'h0, 1'b0, 1'b0);
    push_frame('0, 32'h0000_FFFF, 1'b0, 1'b0);
    push_frame('1, 32'hFFFF_0000, 1'b0, 1'b1);
    settle();

    // Zero length acts as one; highest offset; start and end on one frame
    write_reg(REG_WINDOW_LENGTH, 32'hF000_0000);
    write_reg(REG_FIRST_OFFSET, 32'h0000_07FF);
    push_frame(32'hCAFE_F00D, '1, 1'b1, 1'b1);
    push_frame('1, '0, 1'b1, 1'b0);
    push_frame('0, '1, 1'b0, 1'b1);
    settle();

    // Widest window: fill never completes, nothing comes out
    write_reg(REG_WINDOW_LENGTH, 32'h0FFF_FFFF);
    write_reg(REG_FIRST_OFFSET, 32'h0);
    push_frame('1, '1, 1'b1, 1'b0);
    push_frame('1, '1, 1'b0, 1'b1);
    settle();

    // Long sweep with no gaps on either side
    write_reg(REG_WINDOW_LENGTH, 32'd3);
    write_reg(REG_FIRST_OFFSET, 32'h0000_07FF);
    src_busy = 1'b0;
    snk_busy = 1'b0;
    queue_sweep(3, LONG_SLIDES, 1'b1);
    settle();

    // Back-pressure: hold results off while frames keep coming
    write_reg(REG_WINDOW_LENGTH, 32'd2);
    write_reg(REG_FIRST_OFFSET, {20'($urandom), 12'($urandom)});
    snk_busy = 1'b1;
    hold_serial++;
    queue_sweep(2, 40, 1'b1);
    settle();

    base = frames_pushed;
    while (frames_pushed - base < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0: len_raw = 0;
        1: len_raw = 1;
        2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: len_raw = $urandom_range(2, 8);
        default: len_raw = $urandom_range(9, 40);
      endcase
      len = (len_raw == 0) ? 1 : len_raw;
      case ($urandom_range(0, 7))
        0: ofs = 12'h800;
        1: ofs = 12'h7FF;
        default: ofs = 12'($urandom);
      endcase
      write_reg(REG_WINDOW_LENGTH, {4'($urandom), 28'(len_raw)});
      write_reg(REG_FIRST_OFFSET, {20'($urandom), ofs});
      src_busy = $urandom_range(0, 3) != 0;
      snk_busy = $urandom_range(0, 3) != 0;
      sweeps = $urandom_range(3, 8);
      repeat (sweeps) begin
        if ($urandom_range(0, 5) == 0) begin
          repeat ($urandom_range(1, 3)) begin
            push_frame(rand_frame(), rand_frame(), 1'b0, 1'($urandom_range(0, 1)));
          end
        end
        queue_sweep(len, $urandom_range(0, 12), 1'b0);
      end
      settle();
    end

    if (fail_count == 0 && checksum_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
